### sv/roc_pkg.sv
package roc_pkg;

  localparam int COORD_W = 16;
  localparam int AREA_W  = 32;
  localparam int CFG_W   = 7;
  localparam int SLOT_W  = 6;
  localparam int TOTAL_W = 38;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TEST  = 1'b1;

  typedef struct packed {
    logic                      op;
    logic [SLOT_W-1:0]         slot;
    logic signed [COORD_W-1:0] x_left;
    logic signed [COORD_W-1:0] y_top;
    logic signed [COORD_W-1:0] x_right;
    logic signed [COORD_W-1:0] y_bottom;
  } roc_in_t;

  typedef struct packed {
    logic               culled;
    logic [TOTAL_W-1:0] overlap_total;
  } roc_out_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_left;
    logic signed [COORD_W-1:0] y_top;
    logic signed [COORD_W-1:0] x_right;
    logic signed [COORD_W-1:0] y_bottom;
  } roc_rect_t;

  typedef struct packed {
    logic              valid;
    logic              is_box;
    logic [AREA_W-1:0] area;
  } roc_area_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BOX,
    ST_SCAN,
    ST_RESULT
  } roc_state_t;

endpackage

### sv/roc_rect_mem.sv
module roc_rect_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  roc_pkg::roc_rect_t wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output roc_pkg::roc_rect_t rd_data
);

  roc_pkg::roc_rect_t store_r [DEPTH];
  roc_pkg::roc_rect_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= store_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sv/roc_area_unit.sv
module roc_area_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_is_box,
  input  roc_pkg::roc_rect_t    box,
  input  roc_pkg::roc_rect_t    entry,
  output roc_pkg::roc_area_res_t res,
  output logic                  busy
);

  logic signed [roc_pkg::COORD_W-1:0] il, it, ir, ib;
  logic signed [roc_pkg::COORD_W:0]   w, h;
  logic                               live;

  logic                          s1_valid_r;
  logic                          s1_box_r;
  logic                          s1_live_r;
  logic [roc_pkg::COORD_W-1:0]   s1_w_r;
  logic [roc_pkg::COORD_W-1:0]   s1_h_r;
  roc_pkg::roc_area_res_t        res_r;
  roc_pkg::roc_area_res_t        res_nxt;

  // intersection edges, then width and height with one guard bit
  always_comb begin
    il = (box.x_left   > entry.x_left)   ? box.x_left   : entry.x_left;
    it = (box.y_top    > entry.y_top)    ? box.y_top    : entry.y_top;
    ir = (box.x_right  < entry.x_right)  ? box.x_right  : entry.x_right;
    ib = (box.y_bottom < entry.y_bottom) ? box.y_bottom : entry.y_bottom;
    w  = {ir[roc_pkg::COORD_W-1], ir} - {il[roc_pkg::COORD_W-1], il};
    h  = {ib[roc_pkg::COORD_W-1], ib} - {it[roc_pkg::COORD_W-1], it};
    live = !w[roc_pkg::COORD_W] && (w != '0) && !h[roc_pkg::COORD_W] && (h != '0);
  end

  always_ff @(posedge clk) begin
    s1_box_r  <= in_is_box;
    s1_live_r <= live;
    s1_w_r    <= w[roc_pkg::COORD_W-1:0];
    s1_h_r    <= h[roc_pkg::COORD_W-1:0];
  end

  always_comb begin
    res_nxt.valid  = s1_valid_r;
    res_nxt.is_box = s1_box_r;
    res_nxt.area   = s1_live_r ? (32'(s1_w_r) * 32'(s1_h_r)) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      res_r.valid <= 1'b0;
    end else begin
      s1_valid_r  <= in_valid;
      res_r.valid <= res_nxt.valid;
    end
    res_r.is_box <= res_nxt.is_box;
    res_r.area   <= res_nxt.area;
  end

  assign res  = res_r;
  assign busy = s1_valid_r | res_r.valid;

endmodule

### sv/rect_overlap_cull_test_top.sv
// Write request: stored in the rectangle memory, no result.
// Test request: n = min(active_rects, MAX_RECTS) entries are read from the rectangle
// memory, one per cycle, through one shared two-stage intersect-and-multiply unit;
// the result is registered into out_data once out_valid is clear or taken, and a new request
// is taken only back in idle. The memory read port and the single multiplier set the scan rate.
// Reset (rst_n low, synchronous) clears the sequencer, active_rects and out_valid;
// the rectangle memory is not cleared.
module rect_overlap_cull_test_top #(
  parameter int MAX_RECTS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [roc_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  roc_pkg::roc_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output roc_pkg::roc_out_t             out_data
);

  localparam int AW    = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int CW    = $clog2(MAX_RECTS + 1);
  localparam int SUM_W = roc_pkg::AREA_W + CW;

  roc_pkg::roc_state_t state_r, state_nxt;

  logic [roc_pkg::CFG_W-1:0] cfg_r;
  logic [CW-1:0]             n_r, n_nxt;
  logic [CW-1:0]             idx_r;
  logic                      rd_valid_r;
  roc_pkg::roc_rect_t        box_r;
  logic [SUM_W-1:0]          sum_r;
  logic [roc_pkg::AREA_W-1:0] box_area_r;
  logic                      out_valid_r;
  roc_pkg::roc_out_t         out_data_r, out_data_nxt;

  logic                      in_acc;
  logic                      test_acc;
  logic                      wr_en;
  logic                      rd_en;
  logic                      unit_valid;
  logic                      unit_is_box;
  roc_pkg::roc_rect_t        unit_entry;
  roc_pkg::roc_rect_t        in_rect;
  roc_pkg::roc_rect_t        rd_data;
  roc_pkg::roc_area_res_t    area_res;
  logic                      unit_busy;
  logic                      scan_done;
  logic                      out_load;

  assign in_rect.x_left   = in_data.x_left;
  assign in_rect.y_top    = in_data.y_top;
  assign in_rect.x_right  = in_data.x_right;
  assign in_rect.y_bottom = in_data.y_bottom;

  roc_rect_mem #(
    .DEPTH (MAX_RECTS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_data.slot)),
    .wr_data (in_rect),
    .rd_en   (rd_en),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (rd_data)
  );

  roc_area_unit u_area (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (unit_valid),
    .in_is_box (unit_is_box),
    .box       (box_r),
    .entry     (unit_entry),
    .res       (area_res),
    .busy      (unit_busy)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      roc_pkg::ST_IDLE: begin
        if (test_acc) begin
          state_nxt = roc_pkg::ST_BOX;
        end
      end
      roc_pkg::ST_BOX: begin
        state_nxt = roc_pkg::ST_SCAN;
      end
      roc_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_nxt = roc_pkg::ST_RESULT;
        end
      end
      roc_pkg::ST_RESULT: begin
        if (out_load) begin
          state_nxt = roc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = roc_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready    = 1'b0;
    rd_en       = 1'b0;
    unit_is_box = 1'b0;
    out_load    = 1'b0;
    case (state_r)
      roc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      roc_pkg::ST_BOX: begin
        unit_is_box = 1'b1;
        rd_en       = (idx_r < n_r);
      end
      roc_pkg::ST_SCAN: begin
        rd_en = (idx_r < n_r);
      end
      roc_pkg::ST_RESULT: begin
        out_load = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign in_acc     = in_valid && in_ready;
  assign test_acc   = in_acc && (in_data.op == roc_pkg::OP_TEST);
  // drop writes to slots beyond the table
  assign wr_en      = in_acc && (in_data.op == roc_pkg::OP_WRITE)
                      && (32'(in_data.slot) < MAX_RECTS);
  assign unit_valid = unit_is_box || rd_valid_r;
  assign unit_entry = unit_is_box ? box_r : rd_data;
  assign scan_done  = !(idx_r < n_r) && !rd_valid_r && !unit_busy;
  assign cfg_ready  = 1'b1;

  assign n_nxt = (32'(cfg_r) > MAX_RECTS) ? CW'(MAX_RECTS) : CW'(cfg_r);

  always_comb begin
    out_data_nxt.culled = ({1'b0, sum_r} << 1) > (SUM_W + 1)'(box_area_r);
    out_data_nxt.overlap_total = (64'(sum_r) > 64'(roc_pkg::TOTAL_MAX))
                                 ? roc_pkg::TOTAL_MAX : roc_pkg::TOTAL_W'(sum_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= roc_pkg::ST_IDLE;
      cfg_r       <= '0;
      idx_r       <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rd_valid_r <= rd_en;
      if (cfg_valid && cfg_ready) begin
        cfg_r <= cfg_data;
      end
      if (test_acc) begin
        idx_r <= '0;
      end else if (rd_en) begin
        idx_r <= idx_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (test_acc) begin
      box_r <= in_rect;
      n_r   <= n_nxt;
      sum_r <= '0;
    end else if (area_res.valid) begin
      if (area_res.is_box) begin
        box_area_r <= area_res.area;
      end else begin
        sum_r <= sum_r + SUM_W'(area_res.area);
      end
    end
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_no_area_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == roc_pkg::ST_IDLE) |-> !area_res.valid)
    else $error("area result outside a test");

  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (state_r == roc_pkg::ST_IDLE) && out_valid_r)
    else $error("result load did not present a request");

  a_culled_needs_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.culled) |-> (out_data_r.overlap_total != '0))
    else $error("culled with zero overlap");

endmodule

### tb/rect_overlap_cull_checker.sv
module rect_overlap_cull_checker #(
  parameter int MAX_RECTS = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [roc_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  roc_pkg::roc_in_t          in_data,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  roc_pkg::roc_out_t         out_data,
  output int                        fail_count,
  output int                        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  roc_pkg::roc_rect_t          cull_tab [MAX_RECTS];
  logic [roc_pkg::CFG_W-1:0]   active_cnt;
  roc_pkg::roc_out_t           verdict_q [$];
  roc_pkg::roc_out_t           want;
  int                          mismatches = 0;

  function automatic logic [63:0] rect_area(int l, int t, int r, int b);
    if (r <= l || b <= t) begin
      return 64'd0;
    end
    return 64'(longint'(r - l) * longint'(b - t));
  endfunction

  // Sum the clipped area of the box against every active entry.
  function automatic roc_pkg::roc_out_t predict_cull(roc_pkg::roc_rect_t box);
    logic [63:0]        sum;
    logic [63:0]        box_area;
    roc_pkg::roc_rect_t e;
    roc_pkg::roc_out_t  res;
    int                 n;
    int                 il;
    int                 it;
    int                 ir;
    int                 ib;
    sum = '0;
    n = (active_cnt > MAX_RECTS) ? MAX_RECTS : int'(active_cnt);
    for (int i = 0; i < n; i++) begin
      e = cull_tab[i];
      if (e.x_right > e.x_left && e.y_bottom > e.y_top) begin
        il = (box.x_left > e.x_left) ? box.x_left : e.x_left;
        it = (box.y_top > e.y_top) ? box.y_top : e.y_top;
        ir = (box.x_right < e.x_right) ? box.x_right : e.x_right;
        ib = (box.y_bottom < e.y_bottom) ? box.y_bottom : e.y_bottom;
        sum += rect_area(il, it, ir, ib);
      end
    end
    box_area = rect_area(box.x_left, box.y_top, box.x_right, box.y_bottom);
    res.culled = ((sum << 1) > box_area);
    // Saturate the reported total; the cull decision uses the exact sum.
    res.overlap_total = (sum > 64'(roc_pkg::TOTAL_MAX)) ? roc_pkg::TOTAL_MAX
                                                        : sum[roc_pkg::TOTAL_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      active_cnt = '0;
      verdict_q.delete();
    end else begin
      // Check the result first: it can never belong to a request taken this cycle.
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          mismatches++;
          $display("%0t unexpected result: culled %0b overlap_total %0d",
                   $time, out_data.culled, out_data.overlap_total);
        end else begin
          want = verdict_q.pop_front();
          if (out_data.culled !== want.culled) begin
            mismatches++;
            $display("%0t culled mismatch: expected %0b actual %0b",
                     $time, want.culled, out_data.culled);
          end
          if (out_data.overlap_total !== want.overlap_total) begin
            mismatches++;
            $display("%0t overlap_total mismatch: expected %0d actual %0d",
                     $time, want.overlap_total, out_data.overlap_total);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        active_cnt = cfg_data;
      end
      if (in_valid && in_ready) begin
        if (in_data.op == roc_pkg::OP_WRITE) begin
          if (int'(in_data.slot) < MAX_RECTS) begin
            cull_tab[in_data.slot] = roc_pkg::roc_rect_t'({in_data.x_left, in_data.y_top,
                                                           in_data.x_right,
                                                           in_data.y_bottom});
          end
        end else begin
          verdict_q.push_back(predict_cull(roc_pkg::roc_rect_t'({in_data.x_left,
                                                                 in_data.y_top,
                                                                 in_data.x_right,
                                                                 in_data.y_bottom})));
        end
      end
    end
    pending <= verdict_q.size();
    fail_count <= mismatches;
  end

endmodule

### tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_RECTS    = 64;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 5000;
  localparam int PHASE_ITEMS  = 80;
  localparam int TEST_PCT     = 70;
  localparam int ACTIVE_PLAN [8] = '{64, 127, 1, 64, 0, 40, 64, 63};

  typedef enum int {
    PACE_NONE,
    PACE_SEND,
    PACE_RECV,
    PACE_BOTH
  } pace_t;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [roc_pkg::CFG_W-1:0] cfg_data;
  logic                      in_valid;
  logic                      in_ready;
  roc_pkg::roc_in_t          in_data;
  logic                      out_valid;
  logic                      out_ready;
  roc_pkg::roc_out_t         out_data;

  int fail_count;
  int pending;
  int idle_pct;
  int stall_pct;
  int hold_reqs;
  int hold_seen;
  int hold_left;
  int quiet_cycles = 0;

  rect_overlap_cull_test_top #(
    .MAX_RECTS(MAX_RECTS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  rect_overlap_cull_checker #(
    .MAX_RECTS(MAX_RECTS)
  ) cull_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Drop out_ready at random, or for a long stretch when a hold is requested.
  initial begin
    out_ready = 1'b0;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic roc_pkg::roc_in_t pack_req(logic op, int slot, int l, int t, int r,
                                                int b);
    roc_pkg::roc_in_t q;
    q.op       = op;
    q.slot     = slot[roc_pkg::SLOT_W-1:0];
    q.x_left   = l[roc_pkg::COORD_W-1:0];
    q.y_top    = t[roc_pkg::COORD_W-1:0];
    q.x_right  = r[roc_pkg::COORD_W-1:0];
    q.y_bottom = b[roc_pkg::COORD_W-1:0];
    return q;
  endfunction

  function automatic int extreme_coord();
    case ($urandom_range(3))
      0: begin
        return -32768;
      end
      1: begin
        return 32767;
      end
      2: begin
        return 0;
      end
      default: begin
        return -1;
      end
    endcase
  endfunction

  // Mostly clustered rectangles so that overlaps pile up; some full-range and corner values.
  function automatic roc_pkg::roc_in_t rand_req(logic op, int slot);
    int style;
    int l;
    int t;
    int r;
    int b;
    int tmp;
    style = $urandom_range(99);
    if (style < 65) begin
      l = int'($urandom_range(1100)) - 600;
      t = int'($urandom_range(1100)) - 600;
      r = l + int'($urandom_range(640));
      b = t + int'($urandom_range(640));
      if ($urandom_range(9) == 0) begin
        tmp = l;
        l = r;
        r = tmp;
      end
    end else if (style < 85) begin
      l = $urandom;
      t = $urandom;
      r = $urandom;
      b = $urandom;
    end else begin
      l = extreme_coord();
      t = extreme_coord();
      r = extreme_coord();
      b = extreme_coord();
    end
    return pack_req(op, slot, l, t, r, b);
  endfunction

  task automatic offer_request(input roc_pkg::roc_in_t req);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  // Wait for every outstanding result, then let the block settle.
  task automatic drain_block();
    @(negedge clk);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_active(input int count);
    drain_block();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= roc_pkg::CFG_W'(count);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_pace(input pace_t pace);
    @(posedge clk);
    case (pace)
      PACE_NONE: begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      PACE_SEND: begin
        idle_pct  = 81;
        stall_pct = 0;
      end
      PACE_RECV: begin
        idle_pct  = 0;
        stall_pct = 81;
      end
      default: begin
        idle_pct  = 13;
        stall_pct = 13;
      end
    endcase
  endtask

  task automatic run_phase(input int count);
    logic op;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(99) < TEST_PCT) ? roc_pkg::OP_TEST : roc_pkg::OP_WRITE;
      offer_request(rand_req(op, $urandom_range(MAX_RECTS - 1)));
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    in_data      = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    hold_reqs    = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // No active entries: even the full box sees nothing.
    write_active(0);
    offer_request(pack_req(roc_pkg::OP_TEST, 63, -32768, -32768, 32767, 32767));
    offer_request(pack_req(roc_pkg::OP_WRITE, 0, -32768, -32768, 32767, 32767));
    offer_request(pack_req(roc_pkg::OP_WRITE, 1, 100, 100, -100, -100));
    offer_request(pack_req(roc_pkg::OP_WRITE, 2, 50, 0, 50, 80));
    offer_request(pack_req(roc_pkg::OP_WRITE, 3, 0, 0, 160, 160));
    offer_request(pack_req(roc_pkg::OP_WRITE, 4, -320, -320, -160, -160));

    write_active(5);
    offer_request(pack_req(roc_pkg::OP_TEST, 0, -32768, -32768, 32767, 32767));
    offer_request(pack_req(roc_pkg::OP_TEST, 21, 10, 10, 10, 50));
    offer_request(pack_req(roc_pkg::OP_TEST, 42, 50, 50, 0, 0));
    offer_request(pack_req(roc_pkg::OP_TEST, 63, 0, 0, 160, 160));
    offer_request(pack_req(roc_pkg::OP_TEST, 1, -32768, -32768, -32767, -32767));
    offer_request(pack_req(roc_pkg::OP_TEST, 2, 32766, 32766, 32767, 32767));
    offer_request(pack_req(roc_pkg::OP_TEST, 3, 100, 0, 320, 160));
    // Empty slot 0, then probe exactly half covered and just over half.
    offer_request(pack_req(roc_pkg::OP_WRITE, 0, 0, 0, 0, 0));
    offer_request(pack_req(roc_pkg::OP_TEST, 4, 0, 0, 160, 320));
    offer_request(pack_req(roc_pkg::OP_TEST, 5, 0, 0, 160, 319));

    // Load the rest of the table before any test reads past slot 4.
    set_pace(PACE_BOTH);
    for (int s = 5; s < MAX_RECTS; s++) begin
      offer_request(rand_req(roc_pkg::OP_WRITE, s));
      if ($urandom_range(1) == 1) begin
        offer_request(rand_req(roc_pkg::OP_TEST, $urandom_range(MAX_RECTS - 1)));
      end
    end

    for (int k = 0; k < 8; k++) begin
      if (k == 5) begin
        write_active($urandom_range(MAX_RECTS));
      end else begin
        write_active(ACTIVE_PLAN[k]);
      end
      if (k == 6) begin
        // Hold the result side off while requests keep coming.
        set_pace(PACE_NONE);
        hold_reqs++;
      end else begin
        set_pace(pace_t'(k % 4));
      end
      run_phase(PHASE_ITEMS);
    end

    drain_block();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### rect_overlap_cull_test_top.f
sv/roc_pkg.sv
sv/roc_rect_mem.sv
sv/roc_area_unit.sv
sv/rect_overlap_cull_test_top.sv
tb/rect_overlap_cull_checker.sv
tb/tb.sv
